### hw/rtl/bdwr_pkg.sv
package bdwr_pkg;

   // Block dimensions.
   localparam int NUM_CATEGORIES = 4;
   localparam int STRIDE         = 512;
   localparam int NUM_COUNT_REGS = 4;
   localparam int TOTAL_BITS     = NUM_CATEGORIES * STRIDE;

   // Port field widths.
   localparam int OPCODE_W   = 2;
   localparam int RAND_W     = 32;
   localparam int MASK_W     = 4;
   localparam int STATUS_W   = 2;
   localparam int PCAT_W     = 2;
   localparam int PIDX_W     = 9;
   localparam int REMAIN_W   = 12;
   localparam int SEL_W      = 4;
   localparam int COUNT_W    = 10;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   // Internal widths.
   localparam int CAT_W  = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
   localparam int IDX_W  = $clog2(STRIDE);
   localparam int ADDR_W = $clog2(TOTAL_BITS);
   localparam int CNT_W  = $clog2(TOTAL_BITS + 1);
   localparam int REM_W  = CNT_W + 1;
   localparam int STEP_W = $clog2(RAND_W);
   localparam int CMP_W  = (IDX_W > COUNT_W) ? IDX_W : COUNT_W;
   localparam int SAT_W  = (CNT_W > REMAIN_W) ? CNT_W : REMAIN_W;

   // Opcodes.
   localparam logic [OPCODE_W-1:0] OP_DRAW  = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STAT_DRAWN         = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_DRAWN_CLEARED = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_NONE          = 2'd2;
   localparam logic [STATUS_W-1:0] STAT_DONE          = 2'd3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SELECTION = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT0    = 3'd1;

   localparam logic [REMAIN_W-1:0] REMAIN_MAX = '1;

endpackage

### hw/rtl/bitmap_draw_without_repeat.sv
// Draw-without-repeat bitmap: one used bit per entry, STRIDE entries per category.
// The request channel (req_valid/req_stall) carries an opcode, a random word and a
// clear mask; every request yields exactly one response on rsp_valid/rsp_stall.
// Registers are written on the csr channel (csr_valid/csr_ready, csr_index,
// csr_data); csr_ready is always high. The user must write them only while no
// request is in flight; the block does not enforce it. The used bits sit in a
// single-port-write memory, and all bitmap work is done by a walk that visits one
// bit per cycle; the modulo runs one quotient bit a cycle over the random word.
// A count request walks the bitmap once (after a clear walk for a clear), a draw
// does a count walk, the modulo and a select walk; a draw that has to restart the
// history clears the selection and counts once more. One request is worked on at
// a time; req_stall is high until the result has moved to the output register.
// After reset a clearing pass zeroes the bitmap with req_stall
// high; configuration writes are taken during it. A stalled response holds on
// the output; the block can take the next request meanwhile but will not
// finish it until the output register is free.
module bitmap_draw_without_repeat (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [bdwr_pkg::OPCODE_W-1:0]      req_opcode,
   input  logic [bdwr_pkg::RAND_W-1:0]        req_random_word,
   input  logic [bdwr_pkg::MASK_W-1:0]        req_clear_mask,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [bdwr_pkg::STATUS_W-1:0]      rsp_status,
   output logic [bdwr_pkg::PCAT_W-1:0]        rsp_picked_category,
   output logic [bdwr_pkg::PIDX_W-1:0]        rsp_picked_index,
   output logic [bdwr_pkg::REMAIN_W-1:0]      rsp_remaining,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [bdwr_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [bdwr_pkg::CSR_DATA_W-1:0]    csr_data
);
   import bdwr_pkg::*;

   typedef enum logic [6:0] {
      ST_INIT   = 7'b0000001,
      ST_IDLE   = 7'b0000010,
      ST_CLEAR  = 7'b0000100,
      ST_COUNT  = 7'b0001000,
      ST_MOD    = 7'b0010000,
      ST_SELECT = 7'b0100000,
      ST_FINISH = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [ADDR_W-1:0]         addr_ff, addr_in;
   logic [CAT_W-1:0]          cat_ff, cat_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic                      issue_ff, issue_in;
   logic                      rd_act_ff, rd_act_in;
   logic [ADDR_W-1:0]         rd_addr_ff;
   logic [CAT_W-1:0]          rd_cat_ff;
   logic [IDX_W-1:0]          rd_idx_ff;
   logic                      rd_bit_ff;
   logic [OPCODE_W-1:0]       op_ff, op_in;
   logic [RAND_W-1:0]         rand_ff, rand_in;
   logic [NUM_CATEGORIES-1:0] clr_mask_ff, clr_mask_in;
   logic                      auto_ff, auto_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [REM_W-1:0]          rem_ff, rem_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [STATUS_W-1:0]       res_status_ff, res_status_in;
   logic [CAT_W-1:0]          res_cat_ff, res_cat_in;
   logic [IDX_W-1:0]          res_idx_ff, res_idx_in;
   logic [REMAIN_W-1:0]       res_remain_ff, res_remain_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [PCAT_W-1:0]         rsp_cat_ff;
   logic [PIDX_W-1:0]         rsp_idx_ff;
   logic [REMAIN_W-1:0]       rsp_remain_ff;
   logic                      rsp_load;
   logic [SEL_W-1:0]          selection_ff;
   logic [COUNT_W-1:0]        count_ff [NUM_CATEGORIES];

   logic                      mem [TOTAL_BITS];
   logic                      mem_we;
   logic [ADDR_W-1:0]         mem_waddr;
   logic                      mem_wdata;

   logic [NUM_CATEGORIES-1:0] sel_cats;
   logic                      walk_last;
   logic                      rd_free;
   logic [REMAIN_W-1:0]       sat_cnt;
   logic [REM_W-1:0]          rem_shift;
   logic [REM_W-1:0]          rem_next;

   assign sel_cats  = NUM_CATEGORIES'(selection_ff);
   assign walk_last = (addr_ff == ADDR_W'(TOTAL_BITS - 1));
   assign rd_free   = rd_act_ff && sel_cats[rd_cat_ff] && !rd_bit_ff &&
                      (CMP_W'(rd_idx_ff) < CMP_W'(count_ff[rd_cat_ff]));
   assign sat_cnt   = (SAT_W'(cnt_ff) > SAT_W'(REMAIN_MAX)) ? REMAIN_MAX
                                                             : REMAIN_W'(cnt_ff);

   // One restoring-division step of random_word mod count.
   assign rem_shift = {rem_ff[REM_W-2:0], rand_ff[RAND_W-1]};
   assign rem_next  = (rem_shift >= REM_W'(cnt_ff)) ? rem_shift - REM_W'(cnt_ff)
                                                    : rem_shift;

   assign req_stall           = (state_ff != ST_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_picked_category = rsp_cat_ff;
   assign rsp_picked_index    = rsp_idx_ff;
   assign rsp_remaining       = rsp_remain_ff;

   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      cat_in        = cat_ff;
      idx_in        = idx_ff;
      issue_in      = issue_ff;
      rd_act_in     = 1'b0;
      op_in         = op_ff;
      rand_in       = rand_ff;
      clr_mask_in   = clr_mask_ff;
      auto_in       = auto_ff;
      cnt_in        = cnt_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      res_status_in = res_status_ff;
      res_cat_in    = res_cat_ff;
      res_idx_in    = res_idx_ff;
      res_remain_in = res_remain_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_load      = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = addr_ff;
      mem_wdata     = 1'b0;

      // Walk position steps through every bit, category by category.
      if ((state_ff inside {ST_INIT, ST_CLEAR}) ||
          ((state_ff inside {ST_COUNT, ST_SELECT}) && issue_ff)) begin
         if (walk_last) begin
            addr_in  = '0;
            cat_in   = '0;
            idx_in   = '0;
            issue_in = 1'b0;
         end else begin
            addr_in = addr_ff + 1'b1;
            if (idx_ff == IDX_W'(STRIDE - 1)) begin
               idx_in = '0;
               cat_in = cat_ff + 1'b1;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
      end

      case (state_ff)
         ST_INIT: begin
            mem_we = 1'b1;
            if (walk_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               op_in         = req_opcode;
               rand_in       = req_random_word;
               clr_mask_in   = NUM_CATEGORIES'(req_clear_mask);
               auto_in       = 1'b0;
               cnt_in        = '0;
               res_cat_in    = '0;
               res_idx_in    = '0;
               res_remain_in = '0;
               if (req_opcode == OP_CLEAR) begin
                  state_in = ST_CLEAR;
               end else if ((req_opcode == OP_DRAW) && (sel_cats == '0)) begin
                  res_status_in = STAT_NONE;
                  state_in      = ST_FINISH;
               end else begin
                  issue_in = 1'b1;
                  state_in = ST_COUNT;
               end
            end
         end
         ST_CLEAR: begin
            mem_we = clr_mask_ff[cat_ff];
            if (walk_last) begin
               cnt_in   = '0;
               issue_in = 1'b1;
               state_in = ST_COUNT;
            end
         end
         ST_COUNT: begin
            rd_act_in = issue_ff;
            if (rd_free) begin
               cnt_in = cnt_ff + 1'b1;
            end
            if (!issue_ff && !rd_act_ff) begin
               if (op_ff != OP_DRAW) begin
                  res_status_in = STAT_DONE;
                  res_remain_in = sat_cnt;
                  state_in      = ST_FINISH;
               end else if (cnt_ff != '0) begin
                  rem_in   = '0;
                  step_in  = '0;
                  state_in = ST_MOD;
               end else if (!auto_ff) begin
                  // Everything in the selection has been drawn: restart its history.
                  auto_in     = 1'b1;
                  clr_mask_in = sel_cats;
                  state_in    = ST_CLEAR;
               end else begin
                  res_status_in = STAT_NONE;
                  state_in      = ST_FINISH;
               end
            end
         end
         ST_MOD: begin
            rem_in  = rem_next;
            rand_in = rand_ff << 1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(RAND_W - 1)) begin
               issue_in = 1'b1;
               state_in = ST_SELECT;
            end
         end
         ST_SELECT: begin
            rd_act_in = issue_ff;
            if (rd_free) begin
               if (rem_ff == '0) begin
                  mem_we        = 1'b1;
                  mem_waddr     = rd_addr_ff;
                  mem_wdata     = 1'b1;
                  res_status_in = auto_ff ? STAT_DRAWN_CLEARED : STAT_DRAWN;
                  res_cat_in    = rd_cat_ff;
                  res_idx_in    = rd_idx_ff;
                  res_remain_in = sat_cnt;
                  rd_act_in     = 1'b0;
                  issue_in      = 1'b0;
                  addr_in       = '0;
                  cat_in        = '0;
                  idx_in        = '0;
                  state_in      = ST_FINISH;
               end else begin
                  rem_in = rem_ff - 1'b1;
               end
            end else if (!issue_ff && !rd_act_ff) begin
               res_status_in = STAT_NONE;
               res_cat_in    = '0;
               res_idx_in    = '0;
               res_remain_in = '0;
               state_in      = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_bit_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         addr_ff      <= '0;
         cat_ff       <= '0;
         idx_ff       <= '0;
         issue_ff     <= 1'b0;
         rd_act_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         cat_ff       <= cat_in;
         idx_ff       <= idx_in;
         issue_ff     <= issue_in;
         rd_act_ff    <= rd_act_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff    <= addr_ff;
      rd_cat_ff     <= cat_ff;
      rd_idx_ff     <= idx_ff;
      op_ff         <= op_in;
      rand_ff       <= rand_in;
      clr_mask_ff   <= clr_mask_in;
      auto_ff       <= auto_in;
      cnt_ff        <= cnt_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      res_status_ff <= res_status_in;
      res_cat_ff    <= res_cat_in;
      res_idx_ff    <= res_idx_in;
      res_remain_ff <= res_remain_in;
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_cat_ff    <= PCAT_W'(res_cat_ff);
         rsp_idx_ff    <= PIDX_W'(res_idx_ff);
         rsp_remain_ff <= res_remain_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         selection_ff <= '0;
         for (int i = 0; i < NUM_CATEGORIES; i++) begin
            count_ff[i] <= '0;
         end
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_SELECTION) begin
            selection_ff <= SEL_W'(csr_data);
         end
         for (int i = 0; i < NUM_CATEGORIES; i++) begin
            if ((i < NUM_COUNT_REGS) && (csr_index == CSR_IDX_W'(CSR_COUNT0 + i))) begin
               count_ff[i] <= COUNT_W'(csr_data);
            end
         end
      end
   end

`ifndef SYNTHESIS
   // The pick offset must stay below the number of free entries during the walk.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SELECT) |-> (rem_ff < REM_W'(cnt_ff)))
      else $error("pick offset not below free count");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOD) |-> (cnt_ff != '0))
      else $error("modulo started with zero free entries");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && ((rsp_status == STAT_DRAWN) || (rsp_status == STAT_DRAWN_CLEARED)))
      |-> (rsp_remaining != '0))
      else $error("draw reported with no remaining entries");

   assert property (@(posedge clock) disable iff (reset)
      mem_we |-> ((state_ff == ST_INIT) || (state_ff == ST_CLEAR) ||
                  (state_ff == ST_SELECT)))
      else $error("bitmap written outside a clear or a draw");
`endif

endmodule
